// File: rtl/spirm_pkg.sv
// Package for the SPI mode 3 register burst master.
// Holds operation, status and register index codes plus framing constants.
// No dependencies; used by spi_register_access_master_core.
package spirm_pkg;

    localparam int OP_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W = 16;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 6;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_SUPPLY = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLOSED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUSY   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BUS_OPEN    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS = 2'd1;

    // Bit phases: clock low, data driven, clock high, sample and hold.
    localparam logic [1:0] PH_LOW    = 2'd0;
    localparam logic [1:0] PH_DRIVE  = 2'd1;
    localparam logic [1:0] PH_HIGH   = 2'd2;
    localparam logic [1:0] PH_SAMPLE = 2'd3;

    localparam logic [BYTE_W-1:0] ADDR_MASK = 8'h7E;
    localparam logic [BYTE_W-1:0] READ_FLAG = 8'h80;

endpackage

// File: rtl/spi_register_access_master_core.sv
// SPI mode 3 register burst master, one step per accepted input word.
// Depends on spirm_pkg for codes and constants.
//
//  channel | direction | handshake            | words
//  in      | in        | in_valid / in_ready  | operation, miso_level, reg_address,
//          |           |                      | is_read, burst_length, tx_byte
//  out     | out       | out_valid / out_ready| sck, mosi, cs_n, rx_valid, rx_byte,
//          |           |                      | want_byte, done_res, status, busy_res
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each input word's step is computed from the bus state and lands in the result
// register at the accepting edge, so a word can enter each cycle unless stalled.
// Input stalls while the result word is not taken or a configuration write is offered.
// Reset closes the bus, sets phase_ticks to one and clears all transfer state.
// A configuration write takes priority over an input word in the same cycle.
module spi_register_access_master_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [spirm_pkg::OP_W-1:0]          operation,
    input  logic                                miso_level,
    input  logic [spirm_pkg::ADDR_W-1:0]        reg_address,
    input  logic                                is_read,
    input  logic [spirm_pkg::BYTE_W-1:0]        burst_length,
    input  logic [spirm_pkg::BYTE_W-1:0]        tx_byte,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                sck,
    output logic                                mosi,
    output logic                                cs_n,
    output logic                                rx_valid,
    output logic [spirm_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                want_byte,
    output logic                                done_res,
    output logic [spirm_pkg::STATUS_W-1:0]      status,
    output logic                                busy_res,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spirm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spirm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration and bus state
    logic                               bus_open_reg;
    logic [spirm_pkg::TICK_W-1:0]       phase_ticks_reg;
    logic                               active_reg,       active_next;
    logic                               read_mode_reg,    read_mode_next;
    logic [spirm_pkg::BYTE_W-1:0]       tx_shift_reg,     tx_shift_next;
    logic [spirm_pkg::BYTE_W-1:0]       rx_shift_reg,     rx_shift_next;
    logic [2:0]                         bit_count_reg,    bit_count_next;
    logic [1:0]                         bit_phase_reg,    bit_phase_next;
    logic [spirm_pkg::TICK_W-1:0]       tick_count_reg,   tick_count_next;
    logic [spirm_pkg::BYTE_W-1:0]       bytes_left_reg,   bytes_left_next;
    logic                               sending_addr_reg, sending_addr_next;
    logic                               waiting_reg,      waiting_next;
    logic                               mosi_level_reg,   mosi_level_next;

    // Result register
    logic                               out_valid_reg;
    logic                               sck_reg,       sck_next;
    logic                               mosi_reg,      mosi_next;
    logic                               cs_n_reg,      cs_n_next;
    logic                               rx_valid_reg,  rx_valid_next;
    logic [spirm_pkg::BYTE_W-1:0]       rx_byte_reg,   rx_byte_next;
    logic                               want_byte_reg, want_byte_next;
    logic                               done_reg,      done_next;
    logic [spirm_pkg::STATUS_W-1:0]     status_reg,    status_next;
    logic                               busy_reg;

    logic                               cfg_write;
    logic                               in_accept;
    logic [spirm_pkg::TICK_W:0]         tick_limit;
    logic [spirm_pkg::TICK_W:0]         tick_inc;
    logic [2:0]                         bit_count_inc;
    logic [spirm_pkg::BYTE_W-1:0]       bytes_dec;
    logic [spirm_pkg::BYTE_W-1:0]       framed;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign in_ready  = (!out_valid_reg || out_ready) && !cfg_valid;
    assign in_accept = in_valid && in_ready;

    // A zero phase length behaves as one tick.
    assign tick_limit    = (phase_ticks_reg == '0) ? {{spirm_pkg::TICK_W{1'b0}}, 1'b1}
                                                   : {1'b0, phase_ticks_reg};
    assign tick_inc      = {1'b0, tick_count_reg} + {{spirm_pkg::TICK_W{1'b0}}, 1'b1};
    assign bit_count_inc = bit_count_reg + 3'd1;
    assign bytes_dec     = bytes_left_reg - 8'd1;
    assign framed        = ({reg_address, 2'b00} >> 1 & spirm_pkg::ADDR_MASK)
                           | (is_read ? spirm_pkg::READ_FLAG : '0);

    always_comb
    begin
        active_next       = active_reg;
        read_mode_next    = read_mode_reg;
        tx_shift_next     = tx_shift_reg;
        rx_shift_next     = rx_shift_reg;
        bit_count_next    = bit_count_reg;
        bit_phase_next    = bit_phase_reg;
        tick_count_next   = tick_count_reg;
        bytes_left_next   = bytes_left_reg;
        sending_addr_next = sending_addr_reg;
        waiting_next      = waiting_reg;
        mosi_level_next   = mosi_level_reg;
        rx_valid_next     = 1'b0;
        rx_byte_next      = '0;
        done_next         = 1'b0;
        status_next       = spirm_pkg::STATUS_OK;

        unique case (operation)
            spirm_pkg::OP_TICK:
            begin
                if (bus_open_reg && active_reg && !waiting_reg)
                begin
                    if (tick_inc < tick_limit)
                    begin
                        tick_count_next = tick_inc[spirm_pkg::TICK_W-1:0];
                    end
                    else
                    begin
                        tick_count_next = '0;
                        unique case (bit_phase_reg)
                            spirm_pkg::PH_LOW:
                            begin
                                bit_phase_next  = spirm_pkg::PH_DRIVE;
                                mosi_level_next = tx_shift_reg[spirm_pkg::BYTE_W-1];
                                tx_shift_next   = {tx_shift_reg[spirm_pkg::BYTE_W-2:0], 1'b0};
                            end
                            spirm_pkg::PH_DRIVE:
                            begin
                                bit_phase_next = spirm_pkg::PH_HIGH;
                            end
                            spirm_pkg::PH_HIGH:
                            begin
                                bit_phase_next = spirm_pkg::PH_SAMPLE;
                                rx_shift_next  = {rx_shift_reg[spirm_pkg::BYTE_W-2:0], miso_level};
                            end
                            default:
                            begin
                                bit_phase_next = spirm_pkg::PH_LOW;
                                bit_count_next = bit_count_inc;
                                if (bit_count_inc == 3'd0)
                                begin
                                    // Byte boundary: the address byte does not count.
                                    logic [spirm_pkg::BYTE_W-1:0] left;
                                    left = bytes_left_reg;
                                    if (sending_addr_reg)
                                    begin
                                        sending_addr_next = 1'b0;
                                    end
                                    else
                                    begin
                                        if (read_mode_reg)
                                        begin
                                            rx_valid_next = 1'b1;
                                            rx_byte_next  = rx_shift_reg;
                                        end
                                        left = bytes_dec;
                                    end
                                    bytes_left_next = left;
                                    if (left == '0)
                                    begin
                                        active_next = 1'b0;
                                        done_next   = 1'b1;
                                    end
                                    else if (read_mode_reg)
                                    begin
                                        tx_shift_next  = '0;
                                        bit_count_next = '0;
                                        bit_phase_next = spirm_pkg::PH_LOW;
                                        waiting_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        // Hold the clock high until the next byte arrives.
                                        waiting_next   = 1'b1;
                                        bit_phase_next = spirm_pkg::PH_SAMPLE;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            spirm_pkg::OP_START:
            begin
                if (!bus_open_reg)
                begin
                    status_next = spirm_pkg::STATUS_CLOSED;
                end
                else if (active_reg)
                begin
                    status_next = spirm_pkg::STATUS_BUSY;
                end
                else
                begin
                    active_next       = 1'b1;
                    read_mode_next    = is_read;
                    bytes_left_next   = burst_length;
                    sending_addr_next = 1'b1;
                    rx_shift_next     = '0;
                    tx_shift_next     = framed;
                    bit_count_next    = '0;
                    bit_phase_next    = spirm_pkg::PH_LOW;
                    tick_count_next   = '0;
                    waiting_next      = 1'b0;
                end
            end
            spirm_pkg::OP_SUPPLY:
            begin
                if (bus_open_reg && active_reg && waiting_reg)
                begin
                    tx_shift_next   = tx_byte;
                    bit_count_next  = '0;
                    bit_phase_next  = spirm_pkg::PH_LOW;
                    tick_count_next = '0;
                    waiting_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (!bus_open_reg)
        begin
            sck_next  = 1'b0;
            mosi_next = 1'b0;
            cs_n_next = 1'b0;
        end
        else
        begin
            cs_n_next = !active_next;
            sck_next  = !(active_next && !waiting_next && !bit_phase_next[1]);
            mosi_next = mosi_level_next;
        end
        want_byte_next = bus_open_reg && active_next && waiting_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_open_reg     <= 1'b0;
            phase_ticks_reg  <= {{(spirm_pkg::TICK_W-1){1'b0}}, 1'b1};
            active_reg       <= 1'b0;
            read_mode_reg    <= 1'b0;
            tx_shift_reg     <= '0;
            rx_shift_reg     <= '0;
            bit_count_reg    <= '0;
            bit_phase_reg    <= spirm_pkg::PH_LOW;
            tick_count_reg   <= '0;
            bytes_left_reg   <= '0;
            sending_addr_reg <= 1'b0;
            waiting_reg      <= 1'b0;
            mosi_level_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == spirm_pkg::REG_BUS_OPEN)
            begin
                // Opening or closing aborts any transfer silently.
                bus_open_reg     <= cfg_data[0];
                mosi_level_reg   <= cfg_data[0];
                active_reg       <= 1'b0;
                waiting_reg      <= 1'b0;
                sending_addr_reg <= 1'b0;
                bit_phase_reg    <= spirm_pkg::PH_LOW;
                bit_count_reg    <= '0;
                tick_count_reg   <= '0;
            end
            else if (cfg_index == spirm_pkg::REG_PHASE_TICKS)
            begin
                phase_ticks_reg <= cfg_data;
            end
        end
        else if (in_accept)
        begin
            active_reg       <= active_next;
            read_mode_reg    <= read_mode_next;
            tx_shift_reg     <= tx_shift_next;
            rx_shift_reg     <= rx_shift_next;
            bit_count_reg    <= bit_count_next;
            bit_phase_reg    <= bit_phase_next;
            tick_count_reg   <= tick_count_next;
            bytes_left_reg   <= bytes_left_next;
            sending_addr_reg <= sending_addr_next;
            waiting_reg      <= waiting_next;
            mosi_level_reg   <= mosi_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sck_reg       <= sck_next;
            mosi_reg      <= mosi_next;
            cs_n_reg      <= cs_n_next;
            rx_valid_reg  <= rx_valid_next;
            rx_byte_reg   <= rx_byte_next;
            want_byte_reg <= want_byte_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            busy_reg      <= active_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sck       = sck_reg;
    assign mosi      = mosi_reg;
    assign cs_n      = cs_n_reg;
    assign rx_valid  = rx_valid_reg;
    assign rx_byte   = rx_byte_reg;
    assign want_byte = want_byte_reg;
    assign done_res  = done_reg;
    assign status    = status_reg;
    assign busy_res  = busy_reg;

    // A word waiting for a write byte only exists inside a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> active_reg)
        else $error("waiting for a byte outside a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && want_byte_reg |-> busy_res)
        else $error("byte requested while no transfer runs");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> !busy_res && !want_byte_reg)
        else $error("select released while transfer still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != spirm_pkg::STATUS_OK |-> !done_reg && !rx_valid_reg)
        else $error("refused start reported bus activity");

endmodule

// File: tb/tb_spi_register_access_master_core.sv
// Self-checking testbench for spi_register_access_master_core: a directed table
// followed by random register bursts, every result word checked against its table entry or a predictor.
// Depends on spirm_pkg and the core RTL only.
module tb_spi_register_access_master_core;

    localparam logic [spirm_pkg::OP_W-1:0]        OP_UNUSED      = 2'd3;
    localparam logic [spirm_pkg::CFG_INDEX_W-1:0] REG_SPARE_A    = 2'd2;
    localparam logic [spirm_pkg::CFG_INDEX_W-1:0] REG_SPARE_B    = 2'd3;
    localparam int                                WATCHDOG_LIMIT = 2000;
    localparam int                                ITEM_TARGET    = 800;

    typedef struct packed {
        logic [spirm_pkg::OP_W-1:0]   op;
        logic                         miso;
        logic [spirm_pkg::ADDR_W-1:0] addr;
        logic                         rd;
        logic [spirm_pkg::BYTE_W-1:0] len;
        logic [spirm_pkg::BYTE_W-1:0] txb;
    } bus_word_t;

    typedef struct packed {
        logic                           sck;
        logic                           mosi;
        logic                           cs_n;
        logic                           rx_valid;
        logic [spirm_pkg::BYTE_W-1:0]   rx_byte;
        logic                           want_byte;
        logic                           done_res;
        logic [spirm_pkg::STATUS_W-1:0] status;
        logic                           busy_res;
    } line_result_t;

    typedef struct packed {
        logic                         active;
        logic                         read_mode;
        logic [spirm_pkg::BYTE_W-1:0] tx_sh;
        logic [spirm_pkg::BYTE_W-1:0] rx_sh;
        logic [2:0]                   bit_cnt;
        logic [1:0]                   phase;
        logic [spirm_pkg::TICK_W-1:0] tick_cnt;
        logic [spirm_pkg::BYTE_W-1:0] bytes_left;
        logic                         addr_byte;
        logic                         wait_byte;
        logic                         mosi_lvl;
    } master_state_t;

    typedef struct {
        bit                                is_reg;
        logic [spirm_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic [spirm_pkg::CFG_DATA_W-1:0]  reg_val;
        bus_word_t                         word;
        int                                reps;
        bit                                typed;
        line_result_t                      want;
    } script_row_t;

    logic                              clk;
    logic                              rst_n        = 1'b0;
    logic                              in_valid     = 1'b0;
    logic                              in_ready;
    logic [spirm_pkg::OP_W-1:0]        operation    = spirm_pkg::OP_TICK;
    logic                              miso_level   = 1'b0;
    logic [spirm_pkg::ADDR_W-1:0]      reg_address  = '0;
    logic                              is_read      = 1'b0;
    logic [spirm_pkg::BYTE_W-1:0]      burst_length = '0;
    logic [spirm_pkg::BYTE_W-1:0]      tx_byte      = '0;
    logic                              out_valid;
    logic                              out_ready    = 1'b0;
    logic                              sck;
    logic                              mosi;
    logic                              cs_n;
    logic                              rx_valid;
    logic [spirm_pkg::BYTE_W-1:0]      rx_byte;
    logic                              want_byte;
    logic                              done_res;
    logic [spirm_pkg::STATUS_W-1:0]    status;
    logic                              busy_res;
    logic                              cfg_valid    = 1'b0;
    logic                              cfg_ready;
    logic [spirm_pkg::CFG_INDEX_W-1:0] cfg_index    = spirm_pkg::REG_BUS_OPEN;
    logic [spirm_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    // Predictor copy of the master and its registers.
    master_state_t                bus_state       = '0;
    logic                         bus_is_open     = 1'b0;
    logic [spirm_pkg::TICK_W-1:0] ticks_per_phase = 16'd1;

    line_result_t line_result_q[$];
    script_row_t  script[$];

    int  errors      = 0;
    int  words_sent  = 0;
    int  bursts_done = 0;
    int  rx_seen     = 0;
    int  reg_writes  = 0;
    int  quiet_cycles = 0;
    bit  calm        = 1'b0;
    bit  gappy       = 1'b1;

    line_result_t seen_word;
    line_result_t due_word;

    spi_register_access_master_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bus_word_t mk_word(input logic [spirm_pkg::OP_W-1:0] op,
                                          input logic miso,
                                          input logic [spirm_pkg::ADDR_W-1:0] addr,
                                          input logic rd,
                                          input logic [spirm_pkg::BYTE_W-1:0] len,
                                          input logic [spirm_pkg::BYTE_W-1:0] txb);
        bus_word_t w;
        w = {op, miso, addr, rd, len, txb};
        return w;
    endfunction

    function automatic line_result_t lines(input logic sk, input logic mo, input logic cs,
                                           input logic rxv,
                                           input logic [spirm_pkg::BYTE_W-1:0] rxb,
                                           input logic want, input logic done,
                                           input logic [spirm_pkg::STATUS_W-1:0] st,
                                           input logic busy);
        line_result_t r;
        r = {sk, mo, cs, rxv, rxb, want, done, st, busy};
        return r;
    endfunction

    function automatic script_row_t word_row(input bus_word_t w, input int reps,
                                             input bit typed, input line_result_t want);
        script_row_t row;
        row.is_reg  = 1'b0;
        row.reg_idx = spirm_pkg::REG_BUS_OPEN;
        row.reg_val = '0;
        row.word    = w;
        row.reps    = reps;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    function automatic script_row_t reg_row(input logic [spirm_pkg::CFG_INDEX_W-1:0] idx,
                                            input logic [spirm_pkg::CFG_DATA_W-1:0] val);
        script_row_t row;
        row = word_row('0, 0, 1'b0, '0);
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic bus_word_t random_word(input logic [spirm_pkg::OP_W-1:0] op);
        bus_word_t w;
        w = mk_word(op, 1'($urandom), 6'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        return w;
    endfunction

    function automatic void load_shift(input logic [spirm_pkg::BYTE_W-1:0] value);
        bus_state.tx_sh     = value;
        bus_state.bit_cnt   = 3'd0;
        bus_state.phase     = spirm_pkg::PH_LOW;
        bus_state.tick_cnt  = '0;
        bus_state.wait_byte = 1'b0;
    endfunction

    // Advances the bit timing by one tick. Bit 0 of the result flags a completed
    // read byte, bit 1 the release of select.
    function automatic logic [1:0] serial_tick(input logic miso,
                                               output logic [spirm_pkg::BYTE_W-1:0] rx_out);
        int         lim;
        logic [1:0] flags;
        flags  = 2'b00;
        rx_out = 8'h00;
        lim    = (ticks_per_phase == '0) ? 1 : int'(ticks_per_phase);
        if (int'(bus_state.tick_cnt) + 1 < lim)
        begin
            bus_state.tick_cnt = bus_state.tick_cnt + 16'd1;
            return flags;
        end
        bus_state.tick_cnt = '0;
        unique case (bus_state.phase)
            spirm_pkg::PH_LOW:
            begin
                bus_state.phase    = spirm_pkg::PH_DRIVE;
                bus_state.mosi_lvl = bus_state.tx_sh[7];
                bus_state.tx_sh    = {bus_state.tx_sh[6:0], 1'b0};
            end
            spirm_pkg::PH_DRIVE:
                bus_state.phase = spirm_pkg::PH_HIGH;
            spirm_pkg::PH_HIGH:
            begin
                bus_state.phase = spirm_pkg::PH_SAMPLE;
                bus_state.rx_sh = {bus_state.rx_sh[6:0], miso};
            end
            default:
            begin
                bus_state.phase   = spirm_pkg::PH_LOW;
                bus_state.bit_cnt = bus_state.bit_cnt + 3'd1;
                if (bus_state.bit_cnt == 3'd0)
                begin
                    if (bus_state.addr_byte)
                        bus_state.addr_byte = 1'b0;
                    else
                    begin
                        if (bus_state.read_mode)
                        begin
                            rx_out   = bus_state.rx_sh;
                            flags[0] = 1'b1;
                        end
                        bus_state.bytes_left = bus_state.bytes_left - 8'd1;
                    end
                    if (bus_state.bytes_left == 8'd0)
                    begin
                        bus_state.active = 1'b0;
                        flags[1]         = 1'b1;
                    end
                    else if (bus_state.read_mode)
                        load_shift(8'h00);
                    else
                    begin
                        // A finished write byte parks in the hold phase until
                        // the next data word is supplied.
                        bus_state.wait_byte = 1'b1;
                        bus_state.phase     = spirm_pkg::PH_SAMPLE;
                    end
                end
            end
        endcase
        return flags;
    endfunction

    function automatic line_result_t spi_step(input bus_word_t w);
        line_result_t                 r;
        logic [1:0]                   flags;
        logic [spirm_pkg::BYTE_W-1:0] rxb;
        logic [spirm_pkg::BYTE_W-1:0] framed;
        r = '0;
        unique case (w.op)
            spirm_pkg::OP_TICK:
                if (bus_is_open && bus_state.active && !bus_state.wait_byte)
                begin
                    flags      = serial_tick(w.miso, rxb);
                    r.rx_valid = flags[0];
                    r.done_res = flags[1];
                    r.rx_byte  = flags[0] ? rxb : 8'h00;
                end
            spirm_pkg::OP_START:
                if (!bus_is_open)
                    r.status = spirm_pkg::STATUS_CLOSED;
                else if (bus_state.active)
                    r.status = spirm_pkg::STATUS_BUSY;
                else
                begin
                    framed = {1'b0, w.addr, 1'b0} & spirm_pkg::ADDR_MASK;
                    if (w.rd)
                        framed = framed | spirm_pkg::READ_FLAG;
                    bus_state.active     = 1'b1;
                    bus_state.read_mode  = w.rd;
                    bus_state.bytes_left = w.len;
                    bus_state.addr_byte  = 1'b1;
                    bus_state.rx_sh      = 8'h00;
                    load_shift(framed);
                end
            spirm_pkg::OP_SUPPLY:
                if (bus_is_open && bus_state.active && bus_state.wait_byte)
                    load_shift(w.txb);
            default:
                ;
        endcase
        if (bus_is_open)
        begin
            r.cs_n = !bus_state.active;
            r.sck  = !(bus_state.active && !bus_state.wait_byte &&
                       bus_state.phase < spirm_pkg::PH_HIGH);
            r.mosi = bus_state.mosi_lvl;
        end
        r.want_byte = bus_is_open && bus_state.active && bus_state.wait_byte;
        r.busy_res  = bus_state.active;
        return r;
    endfunction

    function automatic void apply_reg(input logic [spirm_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [spirm_pkg::CFG_DATA_W-1:0] val);
        unique case (idx)
            spirm_pkg::REG_BUS_OPEN:
            begin
                // Opening or closing the bus drops any transfer in flight.
                bus_is_open         = val[0];
                bus_state.active    = 1'b0;
                bus_state.wait_byte = 1'b0;
                bus_state.addr_byte = 1'b0;
                bus_state.phase     = spirm_pkg::PH_LOW;
                bus_state.bit_cnt   = 3'd0;
                bus_state.tick_cnt  = '0;
                bus_state.mosi_lvl  = val[0];
            end
            spirm_pkg::REG_PHASE_TICKS:
                ticks_per_phase = val;
            default:
                ;
        endcase
    endfunction

    task automatic send_word(input bus_word_t w, input bit typed, input line_result_t want);
        line_result_t pred;
        cfg_valid <= 1'b0;
        if (!calm && gappy && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= w.op;
        miso_level   <= w.miso;
        reg_address  <= w.addr;
        is_read      <= w.rd;
        burst_length <= w.len;
        tx_byte      <= w.txb;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        pred = spi_step(w);
        if (pred.done_res)
            bursts_done++;
        line_result_q.push_back(typed ? want : pred);
    endtask

    // Register writes wait until every result word has been taken.
    task automatic write_reg(input logic [spirm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [spirm_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (line_result_q.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    task automatic set_bus(input logic open);
        logic [spirm_pkg::CFG_DATA_W-1:0] val;
        val    = 16'($urandom);
        val[0] = open;
        write_reg(spirm_pkg::REG_BUS_OPEN, val);
    endtask

    task automatic send_noise(input int count);
        bus_word_t w;
        repeat (count)
        begin
            w = random_word(2'($urandom_range(0, 3)));
            if (bus_is_open)
                w.len[7:2] = '0;
            send_word(w, 1'b0, '0);
        end
    endtask

    // One register burst: a start, then ticks and data words until select is
    // released, with stray words, retiming and the odd abort mixed in. The
    // longest burst is always cut short so that the run stays near its size.
    task automatic run_transfer(input logic [spirm_pkg::BYTE_W-1:0] len);
        int        abort_after;
        int        retune_after;
        int        n;
        bus_word_t w;
        gappy        = $urandom_range(0, 3) != 0;
        if (len == 8'd255)
            abort_after = int'($urandom_range(40, 80));
        else
            abort_after = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 80)) : -1;
        retune_after = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 40)) : -1;
        w     = random_word(spirm_pkg::OP_START);
        w.len = len;
        send_word(w, 1'b0, '0);
        n = 0;
        while (bus_state.active)
        begin
            if (n == abort_after)
            begin
                set_bus(1'b0);
                send_noise($urandom_range(1, 4));
                set_bus(1'b1);
                return;
            end
            if (n == retune_after)
                write_reg(spirm_pkg::REG_PHASE_TICKS, 16'($urandom_range(1, 4)));
            if ($urandom_range(0, 11) == 0)
                w = random_word(2'($urandom_range(0, 3)));
            else if (bus_state.wait_byte)
                w = random_word(($urandom_range(0, 4) == 0) ? spirm_pkg::OP_TICK
                                                             : spirm_pkg::OP_SUPPLY);
            else
                w = random_word(spirm_pkg::OP_TICK);
            send_word(w, 1'b0, '0);
            n++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_word = {sck, mosi, cs_n, rx_valid, rx_byte, want_byte, done_res, status,
                         busy_res};
            if (line_result_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected, actual %h", $time, seen_word);
            end
            else
            begin
                due_word = line_result_q.pop_front();
                check_field("sck", 8'(due_word.sck), 8'(seen_word.sck));
                check_field("mosi", 8'(due_word.mosi), 8'(seen_word.mosi));
                check_field("cs_n", 8'(due_word.cs_n), 8'(seen_word.cs_n));
                check_field("rx_valid", 8'(due_word.rx_valid), 8'(seen_word.rx_valid));
                check_field("rx_byte", due_word.rx_byte, seen_word.rx_byte);
                check_field("want_byte", 8'(due_word.want_byte), 8'(seen_word.want_byte));
                check_field("done_res", 8'(due_word.done_res), 8'(seen_word.done_res));
                check_field("status", 8'(due_word.status), 8'(seen_word.status));
                check_field("busy_res", 8'(due_word.busy_res), 8'(seen_word.busy_res));
                if (seen_word.rx_valid === 1'b1)
                    rx_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : result_sink
        bit steady;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
                steady = !steady;
            if (!calm && !steady && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        line_result_t closed_idle;
        line_result_t refused_closed;
        line_result_t open_idle;
        line_result_t refused_busy;
        bit           long_done;
        int           r;
        closed_idle    = lines(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                               spirm_pkg::STATUS_OK, 1'b0);
        refused_closed = lines(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                               spirm_pkg::STATUS_CLOSED, 1'b0);
        open_idle      = lines(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0,
                               spirm_pkg::STATUS_OK, 1'b0);
        refused_busy   = lines(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0,
                               spirm_pkg::STATUS_BUSY, 1'b1);
        long_done      = 1'b0;

        // Closed bus after reset, unused codes, then an empty write burst,
        // a one byte write with ticks while waiting, an abort and a retimed phase.
        script.push_back(word_row(mk_word(spirm_pkg::OP_START, 1'b1, 6'd63, 1'b1, 8'd255, 8'hFF),
                                  1, 1'b1, refused_closed));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b1, 6'd0, 1'b0, 8'd0, 8'h00),
                                  1, 1'b1, closed_idle));
        script.push_back(word_row(mk_word(spirm_pkg::OP_SUPPLY, 1'b0, 6'd0, 1'b0, 8'd0, 8'hFF),
                                  1, 1'b1, closed_idle));
        script.push_back(word_row(mk_word(OP_UNUSED, 1'b1, 6'd63, 1'b1, 8'd255, 8'hFF),
                                  1, 1'b1, closed_idle));
        script.push_back(reg_row(REG_SPARE_A, 16'hFFFF));
        script.push_back(reg_row(REG_SPARE_B, 16'hFFFF));
        script.push_back(reg_row(spirm_pkg::REG_PHASE_TICKS, 16'd0));
        script.push_back(reg_row(spirm_pkg::REG_BUS_OPEN, 16'h0001));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b1, 6'd0, 1'b0, 8'd0, 8'h00),
                                  1, 1'b1, open_idle));
        script.push_back(word_row(mk_word(spirm_pkg::OP_SUPPLY, 1'b0, 6'd0, 1'b0, 8'd0, 8'hA5),
                                  1, 1'b1, open_idle));
        script.push_back(word_row(mk_word(spirm_pkg::OP_START, 1'b0, 6'd0, 1'b0, 8'd0, 8'h00),
                                  1, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_START, 1'b1, 6'd21, 1'b1, 8'd7, 8'h00),
                                  1, 1'b1, refused_busy));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b0, 6'd0, 1'b0, 8'd0, 8'h00),
                                  32, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_START, 1'b1, 6'd63, 1'b0, 8'd1, 8'h00),
                                  1, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b1, 6'd0, 1'b0, 8'd0, 8'h00),
                                  32, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b0, 6'd0, 1'b0, 8'd0, 8'h00),
                                  2, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_SUPPLY, 1'b0, 6'd0, 1'b0, 8'd0, 8'h81),
                                  1, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b1, 6'd0, 1'b0, 8'd0, 8'h00),
                                  32, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_START, 1'b0, 6'd5, 1'b0, 8'd3, 8'h00),
                                  1, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b0, 6'd0, 1'b0, 8'd0, 8'h00),
                                  5, 1'b0, '0));
        script.push_back(reg_row(spirm_pkg::REG_BUS_OPEN, 16'h0000));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b1, 6'd0, 1'b0, 8'd0, 8'h00),
                                  1, 1'b1, closed_idle));
        script.push_back(reg_row(spirm_pkg::REG_BUS_OPEN, 16'h0001));
        script.push_back(reg_row(spirm_pkg::REG_PHASE_TICKS, 16'hFFFF));
        script.push_back(word_row(mk_word(spirm_pkg::OP_START, 1'b1, 6'd1, 1'b1, 8'd0, 8'h00),
                                  1, 1'b0, '0));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b1, 6'd0, 1'b0, 8'd0, 8'h00),
                                  3, 1'b0, '0));
        script.push_back(reg_row(spirm_pkg::REG_PHASE_TICKS, 16'd2));
        script.push_back(word_row(mk_word(spirm_pkg::OP_TICK, 1'b0, 6'd0, 1'b0, 8'd0, 8'h00),
                                  2, 1'b0, '0));
        script.push_back(reg_row(spirm_pkg::REG_BUS_OPEN, 16'h0000));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                repeat (script[i].reps) send_word(script[i].word, script[i].typed, script[i].want);
        end

        while (words_sent < ITEM_TARGET)
        begin
            calm = words_sent >= ITEM_TARGET - 100;
            r = $urandom_range(0, 9);
            if (r == 0)
                write_reg(spirm_pkg::REG_PHASE_TICKS, 16'd0);
            else if (r < 7)
                write_reg(spirm_pkg::REG_PHASE_TICKS, 16'd1);
            else
                write_reg(spirm_pkg::REG_PHASE_TICKS, 16'($urandom_range(2, 4)));
            if (!bus_is_open || $urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    set_bus(1'b0);
                    send_noise($urandom_range(1, 6));
                end
                set_bus(1'b1);
            end
            repeat ($urandom_range(1, 4))
            begin
                if (words_sent < ITEM_TARGET)
                begin
                    if (!long_done && words_sent >= 300)
                    begin
                        long_done = 1'b1;
                        run_transfer(8'd255);
                    end
                    else
                        run_transfer(($urandom_range(0, 5) == 0) ? 8'd0
                                                                  : 8'($urandom_range(1, 3)));
                    if ($urandom_range(0, 3) == 0)
                        send_noise($urandom_range(1, 3));
                end
            end
        end

        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (line_result_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d input words, %0d finished bursts, %0d read bytes, %0d reg writes.",
                 words_sent, bursts_done, rx_seen, reg_writes);
        $display("Field mismatches seen: %0d.", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: spi_register_access_master_core.f
rtl/spirm_pkg.sv
rtl/spi_register_access_master_core.sv
tb/tb_spi_register_access_master_core.sv
